// ===== sv/tty_ld_pkg.sv =====
// ----------------------------------------------------------------------------
// tty_ld_pkg
// Shared codes, character constants and types for the TTY line discipline.
// ----------------------------------------------------------------------------
package tty_ld_pkg;

  localparam logic [1:0] FUNC_BYTE = 2'd0;
  localparam logic [1:0] FUNC_SIG  = 2'd1;
  localparam logic [1:0] FUNC_NONE = 2'd2;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_CMP  = 2'd2;

  localparam logic [2:0] ST_DONE = 3'd0;
  localparam logic [2:0] ST_EOF  = 3'd1;
  localparam logic [2:0] ST_SIG  = 3'd2;
  localparam logic [2:0] ST_INTR = 3'd3;
  localparam logic [2:0] ST_QUIT = 3'd4;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_INTR_CHAR = 3'd1;
  localparam logic [2:0] REG_QUIT_CHAR = 3'd2;
  localparam logic [2:0] REG_ERASE     = 3'd3;
  localparam logic [2:0] REG_KILL      = 3'd4;
  localparam logic [2:0] REG_EOF       = 3'd5;
  localparam logic [2:0] REG_MIN       = 3'd6;
  localparam logic [2:0] REG_READ_SIZE = 3'd7;

  localparam int MB_ICRNL  = 0;
  localparam int MB_IGNCR  = 1;
  localparam int MB_INLCR  = 2;
  localparam int MB_ISIG   = 3;
  localparam int MB_ICANON = 4;
  localparam int MB_ECHO   = 5;

  localparam logic [5:0] MODE_RST      = 6'd57;
  localparam logic [7:0] INTR_RST      = 8'd3;
  localparam logic [7:0] QUIT_RST      = 8'd28;
  localparam logic [7:0] ERASE_RST     = 8'd127;
  localparam logic [7:0] KILL_RST      = 8'd21;
  localparam logic [7:0] EOF_RST       = 8'd4;
  localparam logic [4:0] MIN_RST       = 5'd1;
  localparam logic [4:0] READ_SIZE_RST = 5'd16;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_SP = 8'h20;

  typedef enum logic [1:0] {
    ECHO_CHAR  = 2'd0,
    ECHO_RUB   = 2'd1,
    ECHO_CRNL  = 2'd2
  } echo_kind_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEC  = 6'b000010,
    S_ECHO = 6'b000100,
    S_RD   = 6'b001000,
    S_DATA = 6'b010000,
    S_CMP  = 6'b100000
  } state_t;

endpackage

// ===== sv/tty_ram.sv =====
// ----------------------------------------------------------------------------
// tty_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tty_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tty_line_discipline_top.sv =====
// ----------------------------------------------------------------------------
// tty_line_discipline_top
// Canonical and raw serial line discipline: gathers received bytes in a line
// RAM, echoes them, and delivers the line followed by a completion beat.
// ----------------------------------------------------------------------------
// An input beat is taken only while the sequencer is idle and is decoded in the
// next cycle. The first result is loaded into the output register from the echo
// or completion state that follows decode; a data beat is loaded from the data
// state after a line RAM read state. Each data beat needs its own line RAM read,
// and any beat can be held by an output stall.
// Reset restores the register defaults and empties the line; the RAM is not cleared.
module tty_line_discipline_top #(
  parameter int LINE_MAX = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] item_kind,
  output logic [7:0] byte_value,
  output logic [2:0] read_status,
  output logic [4:0] byte_count,
  output logic       last
);

  import tty_ld_pkg::*;

  localparam int         AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam logic [4:0] LW = 5'(LINE_MAX);

  logic [5:0] mode_bits;
  logic [7:0] interrupt_char, quit_char, erase_char, kill_char, eof_char;
  logic [4:0] min_count, read_size;

  state_t     state, state_next;
  logic [4:0] fill_count;
  logic [1:0] item_func;
  logic [7:0] item_byte;
  echo_kind_t e_kind;
  logic [5:0] e_cnt;
  logic [1:0] e_ph;
  logic [7:0] echo_byte;
  logic       comp_pend;
  logic [2:0] c_status;
  logic [4:0] c_n;
  logic [4:0] idx;

  logic [7:0] rd_data;
  logic       slot_free;
  logic       load;
  logic [1:0] ld_kind;
  logic [7:0] ld_byte;
  logic [2:0] ld_status;
  logic [4:0] ld_count;
  logic       ld_last;

  echo_kind_t d_kind;
  logic [5:0] d_cnt;
  logic       d_comp;
  logic [2:0] d_status;
  logic [4:0] d_n;
  logic [4:0] d_fill;
  logic       d_we;
  logic [7:0] d_wdata;
  logic [7:0] ch;
  logic       skip;
  logic [4:0] size;
  logic [4:0] fill;
  logic [4:0] fill_inc;
  logic       isig, echo_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_bits      <= MODE_RST;
      interrupt_char <= INTR_RST;
      quit_char      <= QUIT_RST;
      erase_char     <= ERASE_RST;
      kill_char      <= KILL_RST;
      eof_char       <= EOF_RST;
      min_count      <= MIN_RST;
      read_size      <= READ_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:      mode_bits      <= cfg_data[5:0];
        REG_INTR_CHAR: interrupt_char <= cfg_data;
        REG_QUIT_CHAR: quit_char      <= cfg_data;
        REG_ERASE:     erase_char     <= cfg_data;
        REG_KILL:      kill_char      <= cfg_data;
        REG_EOF:       eof_char       <= cfg_data;
        REG_MIN:       min_count      <= cfg_data[4:0];
        REG_READ_SIZE: read_size      <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  tty_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_line_ram (
    .clk   (clk),
    .we    (d_we && state == S_DEC),
    .waddr (fill[AW-1:0]),
    .wdata (d_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (rd_data)
  );

  assign in_ready = (state == S_IDLE);

  always_comb begin
    isig    = mode_bits[MB_ISIG];
    echo_on = mode_bits[MB_ECHO];
    size    = (read_size == 5'd0) ? 5'd1 : ((read_size > LW) ? LW : read_size);
    fill    = (fill_count > size) ? size : fill_count;
    fill_inc = fill + 5'd1;
    skip    = 1'b0;
    ch      = item_byte;
    if (mode_bits[MB_ICANON]) begin
      if (item_byte == CH_CR) begin
        if (mode_bits[MB_IGNCR]) begin
          skip = 1'b1;
        end else if (mode_bits[MB_ICRNL]) begin
          ch = CH_NL;
        end
      end else if (item_byte == CH_NL && mode_bits[MB_INLCR]) begin
        ch = CH_CR;
      end
    end
    d_kind   = ECHO_CHAR;
    d_cnt    = 6'd0;
    d_comp   = 1'b0;
    d_status = ST_DONE;
    d_n      = 5'd0;
    d_fill   = fill;
    d_we     = 1'b0;
    d_wdata  = ch;
    if (!mode_bits[MB_ICANON]) begin
      case (item_func)
        FUNC_BYTE: begin
          if (isig && ch == interrupt_char) begin
            d_comp = 1'b1; d_status = ST_INTR; d_fill = 5'd0;
          end else if (isig && ch == quit_char) begin
            d_comp = 1'b1; d_status = ST_QUIT; d_fill = 5'd0;
          end else begin
            d_we   = (fill < LW);
            d_fill = fill_inc;
            d_cnt  = echo_on ? 6'd1 : 6'd0;
            if (fill_inc >= size || (min_count != 5'd0 && fill_inc >= min_count)) begin
              d_comp = 1'b1;
              d_n    = (fill_inc > LW) ? LW : fill_inc;
              d_fill = 5'd0;
            end
          end
        end
        FUNC_SIG: begin
          if (min_count != 5'd0) begin
            d_comp   = 1'b1;
            d_status = (fill != 5'd0) ? ST_DONE : ST_SIG;
            d_n      = fill;
            d_fill   = 5'd0;
          end
        end
        FUNC_NONE: begin
          if (min_count == 5'd0) begin
            d_comp = 1'b1; d_n = fill; d_fill = 5'd0;
          end
        end
        default: ;
      endcase
    end else if (item_func == FUNC_SIG) begin
      d_comp = 1'b1; d_status = ST_SIG; d_fill = 5'd0;
    end else if (item_func == FUNC_BYTE) begin
      if (skip) begin
        d_fill = fill;
      end else if (isig && ch == interrupt_char) begin
        d_comp = 1'b1; d_status = ST_INTR; d_fill = 5'd0;
      end else if (isig && ch == quit_char) begin
        d_comp = 1'b1; d_status = ST_QUIT; d_fill = 5'd0;
      end else if (ch == eof_char) begin
        d_comp   = 1'b1;
        d_status = (fill == 5'd0) ? ST_EOF : ST_DONE;
        d_n      = fill;
        d_fill   = 5'd0;
      end else if (ch == erase_char || ch == CH_BS) begin
        if (fill != 5'd0) begin
          d_fill = fill - 5'd1;
          d_kind = ECHO_RUB;
          d_cnt  = echo_on ? 6'd3 : 6'd0;
        end
      end else if (ch == kill_char) begin
        d_fill = 5'd0;
        d_kind = ECHO_RUB;
        d_cnt  = echo_on ? 6'(3 * fill) : 6'd0;
      end else if (ch == CH_NL) begin
        d_kind = ECHO_CRNL;
        d_cnt  = echo_on ? 6'd2 : 6'd0;
        d_comp = 1'b1;
        d_fill = 5'd0;
        if (fill < size) begin
          d_we = 1'b1;
          d_n  = fill_inc;
        end else begin
          d_n  = fill;
        end
      end else if (fill < size) begin
        d_we   = 1'b1;
        d_fill = fill_inc;
        d_cnt  = echo_on ? 6'd1 : 6'd0;
        if (fill_inc >= size) begin
          d_comp = 1'b1; d_n = fill_inc; d_fill = 5'd0;
        end
      end else begin
        d_comp = 1'b1; d_n = fill; d_fill = 5'd0;
      end
    end
  end

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    load       = 1'b0;
    ld_kind    = KIND_ECHO;
    ld_byte    = 8'd0;
    ld_status  = ST_DONE;
    ld_count   = 5'd0;
    ld_last    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (d_cnt != 6'd0) begin
          state_next = S_ECHO;
        end else if (d_comp) begin
          state_next = (d_n != 5'd0) ? S_RD : S_CMP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ECHO: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_kind = KIND_ECHO;
          case (e_kind)
            ECHO_RUB:  ld_byte = (e_ph == 2'd1) ? CH_SP : CH_BS;
            ECHO_CRNL: ld_byte = (e_ph == 2'd0) ? CH_CR : CH_NL;
            default:   ld_byte = echo_byte;
          endcase
          ld_last = (e_cnt == 6'd1) && !comp_pend;
          if (e_cnt == 6'd1) begin
            if (comp_pend) begin
              state_next = (c_n != 5'd0) ? S_RD : S_CMP;
            end else begin
              state_next = S_IDLE;
            end
          end
        end
      end
      S_RD: begin
        state_next = S_DATA;
      end
      S_DATA: begin
        if (slot_free) begin
          load       = 1'b1;
          ld_kind    = KIND_DATA;
          ld_byte    = rd_data;
          state_next = (idx + 5'd1 == c_n) ? S_CMP : S_RD;
        end
      end
      S_CMP: begin
        if (slot_free) begin
          load       = 1'b1;
          ld_kind    = KIND_CMP;
          ld_status  = c_status;
          ld_count   = c_n;
          ld_last    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= 5'd0;
      out_valid  <= 1'b0;
      e_cnt      <= 6'd0;
      comp_pend  <= 1'b0;
      idx        <= 5'd0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_DEC) begin
        fill_count <= d_fill;
        e_cnt      <= d_cnt;
        comp_pend  <= d_comp;
        idx        <= 5'd0;
      end
      if (state == S_ECHO && load) begin
        e_cnt <= e_cnt - 6'd1;
      end
      if (state == S_DATA && load) begin
        idx <= idx + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      item_func <= func;
      item_byte <= rx_byte;
    end
    if (state == S_DEC) begin
      e_kind    <= d_kind;
      e_ph      <= 2'd0;
      echo_byte <= ch;
      c_status  <= d_status;
      c_n       <= d_n;
    end
    if (state == S_ECHO && load) begin
      e_ph <= (e_ph == 2'd2) ? 2'd0 : e_ph + 2'd1;
    end
    if (load) begin
      item_kind   <= ld_kind;
      byte_value  <= ld_byte;
      read_status <= ld_status;
      byte_count  <= ld_count;
      last        <= ld_last;
    end
  end

endmodule

// ===== sv/tty_ld_checker.sv =====
// ----------------------------------------------------------------------------
// tty_ld_checker
// Port-level checks on the result beats of the TTY line discipline.
// ----------------------------------------------------------------------------
module tty_ld_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] item_kind,
  input logic [7:0] byte_value,
  input logic [2:0] read_status,
  input logic [4:0] byte_count,
  input logic       last
);

  import tty_ld_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(item_kind) && $stable(byte_value)
      && $stable(read_status) && $stable(byte_count) && $stable(last))
    else $error("Stalled result beat changed.");

  a_cmp_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_CMP |-> last && byte_value == 8'd0)
    else $error("Completion beat must be final and carry no byte.");

  a_data_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_DATA |-> !last)
    else $error("Data beat marked final.");

  a_noncmp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind != KIND_CMP |-> read_status == ST_DONE && byte_count == 5'd0)
    else $error("Echo or data beat carries completion fields.");

  a_data_then_data_or_cmp: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && item_kind == KIND_DATA |=>
      !out_valid || item_kind == KIND_DATA || item_kind == KIND_CMP)
    else $error("Data beat followed by an echo beat.");

endmodule

bind tty_line_discipline_top tty_ld_checker u_tty_ld_checker (.*);

// ===== bench/tb_tty_line_discipline_top.sv =====
// ----------------------------------------------------------------------------
// tb_tty_line_discipline_top
// Self-checking bench for the TTY line discipline. A line model kept in a
// small scoreboard class predicts the echo, data and completion beats of every
// accepted event. A directed opening covers the special characters, the
// signal and no-byte events in both modes and a read size shrunk under a held
// line. Random phases with new register settings then follow, with random
// stalls on both channels.
// ----------------------------------------------------------------------------
module tb_tty_line_discipline_top;
  import tty_ld_pkg::*;

  localparam int LINE_MAX = 16;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 80;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PHASES = 12;
  localparam int EVENTS_PER_PHASE = 23;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [2:0] status;
    logic [4:0] count;
    logic       last;
  } ld_beat_t;

  class ld_line_model;
    logic [5:0]  mode;
    logic [7:0]  intr_ch, quit_ch, erase_ch, kill_ch, eof_ch;
    logic [4:0]  min_cnt, rd_size;
    logic [7:0]  line_buf [LINE_MAX];
    int unsigned fill;
    ld_beat_t    due [$];
    int          errors;

    function new();
      mode = MODE_RST;
      intr_ch = INTR_RST;
      quit_ch = QUIT_RST;
      erase_ch = ERASE_RST;
      kill_ch = KILL_RST;
      eof_ch = EOF_RST;
      min_cnt = MIN_RST;
      rd_size = READ_SIZE_RST;
      fill = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        REG_MODE:      mode = val[5:0];
        REG_INTR_CHAR: intr_ch = val;
        REG_QUIT_CHAR: quit_ch = val;
        REG_ERASE:     erase_ch = val;
        REG_KILL:      kill_ch = val;
        REG_EOF:       eof_ch = val;
        REG_MIN:       min_cnt = val[4:0];
        REG_READ_SIZE: rd_size = val[4:0];
        default: ;
      endcase
    endfunction

    function void add_beat(logic [1:0] kind, logic [7:0] value, logic [2:0] status,
                           logic [4:0] count);
      ld_beat_t b;
      b.kind = kind;
      b.value = value;
      b.status = status;
      b.count = count;
      b.last = 1'b0;
      due.push_back(b);
    endfunction

    function void echo_byte(logic [7:0] ch);
      if (mode[MB_ECHO]) add_beat(KIND_ECHO, ch, ST_DONE, 5'd0);
    endfunction

    function void rub_out();
      echo_byte(CH_BS);
      echo_byte(CH_SP);
      echo_byte(CH_BS);
    endfunction

    // The held bytes go out only for a normal or end-of-file completion.
    function void end_read(logic [2:0] st);
      int unsigned n;
      n = 0;
      if (st == ST_DONE || st == ST_EOF) begin
        n = (fill > LINE_MAX) ? LINE_MAX : fill;
        for (int i = 0; i < n; i++) add_beat(KIND_DATA, line_buf[i], ST_DONE, 5'd0);
      end
      add_beat(KIND_CMP, 8'd0, st, 5'(n));
      fill = 0;
    endfunction

    function void keep(logic [7:0] ch);
      if (fill < LINE_MAX) line_buf[fill] = ch;
      fill++;
    endfunction

    function void take_event(logic [1:0] f, logic [7:0] rx);
      int unsigned size;
      int unsigned start;
      logic [7:0]  ch;
      logic        sig_on;
      logic        skip;
      ld_beat_t    tail;
      size = rd_size;
      if (size == 0) size = 1;
      if (size > LINE_MAX) size = LINE_MAX;
      if (fill > size) fill = size;
      sig_on = mode[MB_ISIG];
      ch = rx;
      skip = 1'b0;
      start = due.size();
      if (!mode[MB_ICANON]) begin
        if (f == FUNC_BYTE) begin
          if (sig_on && ch == intr_ch) end_read(ST_INTR);
          else if (sig_on && ch == quit_ch) end_read(ST_QUIT);
          else begin
            keep(ch);
            echo_byte(ch);
            if (fill >= size || (min_cnt != 0 && fill >= min_cnt)) end_read(ST_DONE);
          end
        end else if (f == FUNC_SIG) begin
          if (min_cnt != 0) end_read(fill > 0 ? ST_DONE : ST_SIG);
        end else if (f == FUNC_NONE) begin
          if (min_cnt == 0) end_read(ST_DONE);
        end
      end else if (f == FUNC_SIG) begin
        end_read(ST_SIG);
      end else if (f == FUNC_BYTE) begin
        if (ch == CH_CR) begin
          if (mode[MB_IGNCR]) skip = 1'b1;
          else if (mode[MB_ICRNL]) ch = CH_NL;
        end else if (ch == CH_NL && mode[MB_INLCR]) begin
          ch = CH_CR;
        end
        if (!skip) begin
          if (sig_on && ch == intr_ch) begin
            end_read(ST_INTR);
          end else if (sig_on && ch == quit_ch) begin
            end_read(ST_QUIT);
          end else if (ch == eof_ch) begin
            end_read(fill == 0 ? ST_EOF : ST_DONE);
          end else if (ch == erase_ch || ch == CH_BS) begin
            if (fill > 0) begin
              fill--;
              rub_out();
            end
          end else if (ch == kill_ch) begin
            while (fill > 0) begin
              fill--;
              rub_out();
            end
          end else if (ch == CH_NL) begin
            echo_byte(CH_CR);
            echo_byte(CH_NL);
            if (fill < size) keep(CH_NL);
            end_read(ST_DONE);
          end else if (fill < size) begin
            keep(ch);
            echo_byte(ch);
            if (fill >= size) end_read(ST_DONE);
          end else begin
            end_read(ST_DONE);
          end
        end
      end
      if (due.size() > start) begin
        tail = due.pop_back();
        tail.last = 1'b1;
        due.push_back(tail);
      end
    endfunction

    function void report(string field, logic [7:0] want_v, logic [7:0] got_v);
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want_v, got_v);
    endfunction

    function void check_beat(ld_beat_t got);
      ld_beat_t want;
      if (due.size() == 0) begin
        errors++;
        $display({"%0t: unexpected beat, expected none, actual kind %0h value %0h",
                  " status %0h count %0h last %0h"},
                 $time, got.kind, got.value, got.status, got.count, got.last);
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.kind) report("item_kind", want.kind, got.kind);
      if (got.value !== want.value) report("byte_value", want.value, got.value);
      if (got.status !== want.status) report("read_status", want.status, got.status);
      if (got.count !== want.count) report("byte_count", want.count, got.count);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_MODE;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] func = FUNC_BYTE;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] item_kind;
  logic [7:0] byte_value;
  logic [2:0] read_status;
  logic [4:0] byte_count;
  logic       last;
  logic       steady = 1'b0;

  ld_line_model tracker = new();

  tty_line_discipline_top #(.LINE_MAX(LINE_MAX)) DUT (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_beat({item_kind, byte_value, read_status, byte_count, last});
  end

  task automatic send_event(logic [1:0] f, logic [7:0] ch);
    while (!steady && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    rx_byte <= ch;
    do @(posedge clk); while (!in_ready);
    tracker.take_event(f, ch);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Events without results may still be in flight, so the block gets extra
  // cycles after the last expected beat.
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (tracker.due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] char_for(int p, logic [7:0] dflt);
    if (p == 2) return 8'h00;
    if (p == 3) return 8'hFF;
    return $urandom_range(0, 1) ? dflt : 8'($urandom_range(0, 255));
  endfunction

  // Canonical phases get mostly text lines with editing characters mixed in;
  // raw phases get random bytes with signal and no-byte events.
  function automatic void pick_event(output logic [1:0] f, output logic [7:0] ch);
    int r;
    r = $urandom_range(0, 99);
    f = FUNC_BYTE;
    ch = 8'($urandom_range(33, 126));
    if (tracker.mode[MB_ICANON]) begin
      if (r < 60) ch = 8'($urandom_range(33, 126));
      else if (r < 72) ch = r[0] ? CH_CR : CH_NL;
      else if (r < 77) ch = r[0] ? tracker.erase_ch : CH_BS;
      else if (r < 80) ch = tracker.kill_ch;
      else if (r < 84) ch = tracker.eof_ch;
      else if (r < 87) ch = r[0] ? tracker.intr_ch : tracker.quit_ch;
      else if (r < 90) f = FUNC_SIG;
      else if (r < 93) f = r[0] ? FUNC_NONE : FUNC_SPARE;
      else ch = 8'($urandom_range(0, 255));
    end else begin
      if (r < 70) ch = 8'($urandom_range(0, 255));
      else if (r < 74) ch = r[0] ? tracker.intr_ch : tracker.quit_ch;
      else if (r < 84) f = FUNC_SIG;
      else if (r < 95) f = FUNC_NONE;
      else begin
        f = FUNC_SPARE;
        ch = 8'($urandom_range(0, 255));
      end
    end
  endfunction

  initial begin
    int         counted;
    logic [1:0] f;
    logic [7:0] ch;
    logic [5:0] m;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_event(FUNC_BYTE, "a");
    send_event(FUNC_BYTE, 8'h00);
    send_event(FUNC_BYTE, 8'hFF);
    send_event(FUNC_BYTE, ERASE_RST);
    send_event(FUNC_BYTE, CH_BS);
    send_event(FUNC_BYTE, "b");
    send_event(FUNC_BYTE, KILL_RST);
    send_event(FUNC_BYTE, "c");
    send_event(FUNC_BYTE, CH_CR);
    send_event(FUNC_BYTE, EOF_RST);
    send_event(FUNC_BYTE, "d");
    send_event(FUNC_BYTE, EOF_RST);
    send_event(FUNC_BYTE, "e");
    send_event(FUNC_SIG, 8'h00);
    send_event(FUNC_BYTE, "f");
    send_event(FUNC_BYTE, INTR_RST);
    send_event(FUNC_BYTE, QUIT_RST);
    send_event(FUNC_SPARE, 8'hA5);
    send_event(FUNC_NONE, 8'h5A);

    // Shrink the read size under a held line, then overflow it.
    send_event(FUNC_BYTE, "g");
    send_event(FUNC_BYTE, "h");
    send_event(FUNC_BYTE, "i");
    drain();
    write_reg(REG_READ_SIZE, 8'd2);
    send_event(FUNC_BYTE, "k");

    drain();
    write_reg(REG_MODE, 8'h28);
    write_reg(REG_MIN, 8'd0);
    send_event(FUNC_SIG, 8'h00);
    send_event(FUNC_NONE, 8'h00);
    drain();
    write_reg(REG_MIN, 8'd3);
    send_event(FUNC_SIG, 8'h00);
    send_event(FUNC_BYTE, "q");
    send_event(FUNC_SIG, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      m = 6'($urandom_range(0, 63));
      if (p == 0) m = 6'h3F;
      else if (p == 1) m = 6'h00;
      else if (p % 4 == 1) m[MB_ICANON] = 1'b0;
      else if (p % 2 == 0) m[MB_ICANON] = 1'b1;
      write_reg(REG_MODE, {2'b00, m});
      write_reg(REG_INTR_CHAR, char_for(p, INTR_RST));
      write_reg(REG_QUIT_CHAR, char_for(p, QUIT_RST));
      write_reg(REG_ERASE, char_for(p, ERASE_RST));
      write_reg(REG_KILL, char_for(p, KILL_RST));
      write_reg(REG_EOF, char_for(p, EOF_RST));
      write_reg(REG_MIN, p == 1 ? 8'd16 : p == 5 ? 8'd0 : 8'($urandom_range(0, 16)));
      write_reg(REG_READ_SIZE, p == 2 ? 8'd20 : p == 3 ? 8'd1 : p == 4 ? 8'd16 :
                               p == 6 ? 8'd0 : 8'($urandom_range(1, 16)));
      steady <= (p == 7);
      counted = 0;
      while (counted < EVENTS_PER_PHASE) begin
        pick_event(f, ch);
        send_event(f, ch);
        if (f != FUNC_SPARE) counted++;
      end
    end

    drain();
    if (tracker.due.size() != 0)
      $display("%0t: %0d expected beats never arrived", $time, tracker.due.size());
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
